[rtl/bqc_pkg.sv]
// Package: shared types and constants for the biquad cascade filter.
package bqc_pkg;

    localparam int SampleW = 16;
    localparam int CoefW   = 24;
    localparam int DelayW  = 40;
    localparam int NumW    = 42;
    localparam int SlotW   = 3;
    localparam int Slots   = 6;

    localparam logic [SlotW-1:0] SLOT_B0 = 3'd0;
    localparam logic [SlotW-1:0] SLOT_B1 = 3'd1;
    localparam logic [SlotW-1:0] SLOT_B2 = 3'd2;
    localparam logic [SlotW-1:0] SLOT_A0 = 3'd3;
    localparam logic [SlotW-1:0] SLOT_A1 = 3'd4;
    localparam logic [SlotW-1:0] SLOT_A2 = 3'd5;

    typedef enum logic [3:0] {
        OP_IDLE,
        OP_WRITE,
        OP_LOAD,
        OP_NUM,
        OP_DIV_START,
        OP_DIV_STEP,
        OP_YFIX,
        OP_D0A,
        OP_D0B,
        OP_D1A,
        OP_D1B,
        OP_NEXT,
        OP_DONE
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic div_done;
    } status_t;

endpackage

[rtl/bqc_stream_if.sv]
// Interfaces: input and output item channels.
interface bqc_in_if;
    logic              valid;
    logic              ready;
    logic              kind;
    logic signed [15:0] sample_in;
    logic [1:0]        coef_section;
    logic [2:0]        coef_slot;
    logic signed [23:0] coef_value;
    modport source (output valid, kind, sample_in, coef_section, coef_slot, coef_value,
                    input ready);
    modport sink   (input valid, kind, sample_in, coef_section, coef_slot, coef_value,
                    output ready);
endinterface

interface bqc_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample_out;
    logic               clipped;
    logic               divide_fault;
    modport source (output valid, sample_out, clipped, divide_fault, input ready);
    modport sink   (input valid, sample_out, clipped, divide_fault, output ready);
endinterface

[rtl/biquad_cascade_filter.sv]
// Top level: biquad cascade filter, controller plus datapath.
//  channel | dir | payload
//  in_ch   | in  | kind, sample_in, coef_section, coef_slot, coef_value
//  out_ch  | out | sample_out, clipped, divide_fault
// A coefficient item is written on acceptance. A sample item runs through each
// section in turn (two setup steps, 42 serial divider steps, six update steps);
// the result is then presented on out_ch.
// Reset clears coefficients, delays and control at once.
// Result holds while out_ch.ready is low; no new item is taken until it goes.
module biquad_cascade_filter #(
    parameter int SECTIONS = 4
) (
    input logic         clk,
    input logic         rst_n,
    bqc_in_if.sink      in_ch,
    bqc_out_if.source   out_ch
);
    bqc_pkg::cmd_t    cmd;
    bqc_pkg::status_t status;
    logic [((SECTIONS > 1) ? $clog2(SECTIONS) : 1)-1:0] sec;

    bqc_controller #(.SECTIONS(SECTIONS)) u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_ch.valid), .in_kind(in_ch.kind), .in_ready(in_ch.ready),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready),
        .status(status), .cmd(cmd), .sec(sec)
    );

    bqc_datapath #(.SECTIONS(SECTIONS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sec(sec),
        .x_in(in_ch.sample_in), .wr_section(in_ch.coef_section),
        .wr_slot(in_ch.coef_slot), .wr_value(in_ch.coef_value),
        .status(status), .y_out(out_ch.sample_out),
        .clip_out(out_ch.clipped), .fault_out(out_ch.divide_fault)
    );
endmodule

[rtl/bqc_datapath.sv]
// Datapath: coefficient and delay stores, multiplier, serial divider.
module bqc_datapath #(
    parameter int SECTIONS = 4
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  bqc_pkg::cmd_t                     cmd,
    input  logic [((SECTIONS > 1) ? $clog2(SECTIONS) : 1)-1:0] sec,
    input  logic signed [bqc_pkg::SampleW-1:0] x_in,
    input  logic [1:0]                        wr_section,
    input  logic [bqc_pkg::SlotW-1:0]         wr_slot,
    input  logic signed [bqc_pkg::CoefW-1:0]  wr_value,
    output bqc_pkg::status_t                  status,
    output logic signed [bqc_pkg::SampleW-1:0] y_out,
    output logic                              clip_out,
    output logic                              fault_out
);
    localparam int SecW = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
    localparam int QW   = 27;
    localparam int QCW  = $clog2(bqc_pkg::NumW + 1);

    logic [bqc_pkg::Slots*bqc_pkg::CoefW-1:0] coef_reg [SECTIONS];
    logic signed [bqc_pkg::DelayW-1:0] d0_reg [SECTIONS];
    logic signed [bqc_pkg::DelayW-1:0] d1_reg [SECTIONS];

    logic [SecW-1:0] si;
    logic signed [bqc_pkg::CoefW-1:0] b0, b1, b2, a0, a1, a2;
    logic signed [bqc_pkg::SampleW-1:0] x_reg, y_reg;
    logic signed [bqc_pkg::NumW-1:0] acc_reg;
    logic signed [bqc_pkg::SampleW+bqc_pkg::CoefW-1:0] prod_full;
    logic signed [bqc_pkg::NumW-1:0] prod;
    logic signed [bqc_pkg::SampleW-1:0] mul_a;
    logic signed [bqc_pkg::CoefW-1:0] mul_b;
    logic clip_reg, fault_reg, neg_reg;
    logic [bqc_pkg::NumW-1:0] rem_reg, dvd_reg;
    logic [bqc_pkg::CoefW-1:0] dvs_reg;
    logic [QW-1:0] q_reg;
    logic [QCW-1:0] qcnt_reg;
    logic [bqc_pkg::NumW:0] trial;
    logic [bqc_pkg::NumW-1:0] rem_sh;
    logic signed [bqc_pkg::NumW-1:0] d_sum;
    logic signed [bqc_pkg::DelayW-1:0] d_sat;
    logic signed [QW:0] q_signed;

    assign si = sec;
    assign b0 = coef_reg[si][0*bqc_pkg::CoefW +: bqc_pkg::CoefW];
    assign b1 = coef_reg[si][1*bqc_pkg::CoefW +: bqc_pkg::CoefW];
    assign b2 = coef_reg[si][2*bqc_pkg::CoefW +: bqc_pkg::CoefW];
    assign a0 = coef_reg[si][3*bqc_pkg::CoefW +: bqc_pkg::CoefW];
    assign a1 = coef_reg[si][4*bqc_pkg::CoefW +: bqc_pkg::CoefW];
    assign a2 = coef_reg[si][5*bqc_pkg::CoefW +: bqc_pkg::CoefW];

    // Pick multiplier operands for each step
    always_comb
    begin
        mul_a = x_reg;
        mul_b = b0;
        case (cmd.op)
            bqc_pkg::OP_D0A: begin mul_a = x_reg; mul_b = b1; end
            bqc_pkg::OP_D0B: begin mul_a = y_reg; mul_b = a1; end
            bqc_pkg::OP_D1A: begin mul_a = x_reg; mul_b = b2; end
            bqc_pkg::OP_D1B: begin mul_a = y_reg; mul_b = a2; end
            default:         begin mul_a = x_reg; mul_b = b0; end
        endcase
    end
    assign prod_full = mul_a * mul_b;
    assign prod      = bqc_pkg::NumW'(prod_full);

    // Restoring divider step on magnitudes
    assign rem_sh = {rem_reg[bqc_pkg::NumW-2:0], dvd_reg[bqc_pkg::NumW-1]};
    assign trial  = {1'b0, rem_sh} - {{(bqc_pkg::NumW-bqc_pkg::CoefW+1){1'b0}}, dvs_reg};
    assign q_signed = neg_reg ? -$signed({1'b0, q_reg}) : $signed({1'b0, q_reg});

    // Delay update: saturate the final sum
    always_comb
    begin
        if (cmd.op == bqc_pkg::OP_D0B)
            d_sum = acc_reg - prod + bqc_pkg::NumW'(d1_reg[si]);
        else
            d_sum = acc_reg - prod;
        if (d_sum > bqc_pkg::NumW'(64'sd549755813887))
            d_sat = 40'sh7FFFFFFFFF;
        else if (d_sum < -bqc_pkg::NumW'(64'sd549755813888))
            d_sat = 40'sh8000000000;
        else
            d_sat = d_sum[bqc_pkg::DelayW-1:0];
    end

    // Advance datapath registers per command
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < SECTIONS; i++) begin
                coef_reg[i] <= '0;
                d0_reg[i]   <= '0;
                d1_reg[i]   <= '0;
            end
            x_reg     <= '0;
            y_reg     <= '0;
            acc_reg   <= '0;
            neg_reg   <= 1'b0;
            rem_reg   <= '0;
            dvd_reg   <= '0;
            dvs_reg   <= '0;
            q_reg     <= '0;
            clip_reg  <= 1'b0;
            fault_reg <= 1'b0;
            qcnt_reg  <= '0;
        end else begin
            case (cmd.op)
                bqc_pkg::OP_WRITE: begin
                    if (32'(wr_section) < SECTIONS && wr_slot <= bqc_pkg::SLOT_A2)
                        coef_reg[wr_section[SecW-1:0]][wr_slot*bqc_pkg::CoefW +:
                            bqc_pkg::CoefW] <= wr_value;
                end
                bqc_pkg::OP_LOAD: begin
                    x_reg     <= x_in;
                    clip_reg  <= 1'b0;
                    fault_reg <= 1'b0;
                end
                bqc_pkg::OP_NUM: acc_reg <= prod + bqc_pkg::NumW'(d0_reg[si]);
                bqc_pkg::OP_DIV_START: begin
                    dvd_reg  <= acc_reg[bqc_pkg::NumW-1] ? bqc_pkg::NumW'(-acc_reg)
                                                          : acc_reg;
                    dvs_reg  <= a0[bqc_pkg::CoefW-1] ? bqc_pkg::CoefW'(-a0) : a0;
                    neg_reg  <= acc_reg[bqc_pkg::NumW-1] ^ a0[bqc_pkg::CoefW-1];
                    rem_reg  <= '0;
                    q_reg    <= '0;
                    qcnt_reg <= QCW'(bqc_pkg::NumW);
                end
                bqc_pkg::OP_DIV_STEP: begin
                    dvd_reg <= {dvd_reg[bqc_pkg::NumW-2:0], 1'b0};
                    if (!trial[bqc_pkg::NumW]) begin
                        rem_reg <= trial[bqc_pkg::NumW-1:0];
                        q_reg   <= {q_reg[QW-2:0], 1'b1} | {QW{q_reg[QW-1]}};
                    end else begin
                        rem_reg <= rem_sh;
                        q_reg   <= {q_reg[QW-2:0], 1'b0} | {QW{q_reg[QW-1]}};
                    end
                    qcnt_reg <= qcnt_reg - 1'b1;
                end
                bqc_pkg::OP_YFIX: begin
                    if (a0 == '0) begin
                        y_reg     <= '0;
                        fault_reg <= 1'b1;
                    end else if (q_signed > 28'sd32767) begin
                        y_reg    <= 16'sh7FFF;
                        clip_reg <= 1'b1;
                    end else if (q_signed < -28'sd32768) begin
                        y_reg    <= 16'sh8000;
                        clip_reg <= 1'b1;
                    end else begin
                        y_reg <= q_signed[bqc_pkg::SampleW-1:0];
                    end
                end
                bqc_pkg::OP_D0A, bqc_pkg::OP_D1A: acc_reg <= prod;
                bqc_pkg::OP_D0B: d0_reg[si] <= d_sat;
                bqc_pkg::OP_D1B: d1_reg[si] <= d_sat;
                bqc_pkg::OP_NEXT: x_reg <= y_reg;
                default: ;
            endcase
        end
    end

    assign status.div_done = (qcnt_reg == QCW'(1));
    assign y_out     = x_reg;
    assign clip_out  = clip_reg;
    assign fault_out = fault_reg;
endmodule

[rtl/bqc_controller.sv]
// Controller: sequences sections and the per-section arithmetic steps.
module bqc_controller #(
    parameter int SECTIONS = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_kind,
    output logic                          in_ready,
    output logic                          out_valid,
    input  logic                          out_ready,
    input  bqc_pkg::status_t              status,
    output bqc_pkg::cmd_t                 cmd,
    output logic [((SECTIONS > 1) ? $clog2(SECTIONS) : 1)-1:0] sec
);
    localparam int SecW = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;

    typedef enum logic [2:0] {
        ST_IDLE, ST_NUM, ST_DSTART, ST_DIV, ST_UPD, ST_OUT
    } state_t;

    state_t state_reg;
    logic [SecW-1:0] sec_reg;
    logic [2:0] step_reg;
    logic accept;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    assign accept    = in_valid && in_ready;
    assign sec       = sec_reg;

    // Decode command from state
    always_comb
    begin
        cmd.op = bqc_pkg::OP_IDLE;
        unique case (state_reg)
            ST_IDLE:   if (accept) cmd.op = in_kind ? bqc_pkg::OP_WRITE : bqc_pkg::OP_LOAD;
            ST_NUM:    cmd.op = bqc_pkg::OP_NUM;
            ST_DSTART: cmd.op = bqc_pkg::OP_DIV_START;
            ST_DIV:    cmd.op = bqc_pkg::OP_DIV_STEP;
            ST_UPD: begin
                unique case (step_reg)
                    3'd0:    cmd.op = bqc_pkg::OP_YFIX;
                    3'd1:    cmd.op = bqc_pkg::OP_D0A;
                    3'd2:    cmd.op = bqc_pkg::OP_D0B;
                    3'd3:    cmd.op = bqc_pkg::OP_D1A;
                    3'd4:    cmd.op = bqc_pkg::OP_D1B;
                    default: cmd.op = bqc_pkg::OP_NEXT;
                endcase
            end
            ST_OUT:    cmd.op = bqc_pkg::OP_DONE;
            default:   cmd.op = bqc_pkg::OP_IDLE;
        endcase
    end

    // Hold state and step sections
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
            sec_reg   <= '0;
            step_reg  <= '0;
        end else begin
            unique case (state_reg)
                ST_IDLE: if (accept && !in_kind) begin
                    state_reg <= ST_NUM;
                    sec_reg   <= '0;
                end
                ST_NUM:    state_reg <= ST_DSTART;
                ST_DSTART: state_reg <= ST_DIV;
                ST_DIV: if (status.div_done) begin
                    state_reg <= ST_UPD;
                    step_reg  <= '0;
                end
                ST_UPD: begin
                    if (step_reg == 3'd5) begin
                        if (sec_reg == SecW'(SECTIONS - 1)) state_reg <= ST_OUT;
                        else begin
                            sec_reg   <= sec_reg + 1'b1;
                            state_reg <= ST_NUM;
                        end
                    end
                    step_reg <= step_reg + 1'b1;
                end
                ST_OUT: if (out_ready) state_reg <= ST_IDLE;
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule
